// ----- design/lsh_pkg.sv -----
// shared types and result codes for the link set-up handshake
package lsh_pkg;

	localparam logic [1:0] RES_NONE  = 2'd0;
	localparam logic [1:0] RES_FRAME = 2'd1;
	localparam logic [1:0] RES_UP    = 2'd2;
	localparam logic [1:0] RES_FAIL  = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] res;
	} req_t;

endpackage

// ----- design/link_setup_handshake.sv -----
// top level of the link set-up handshake
// Sender side of a SET/UA link set-up. An input beat is registered and, as it leaves that
// register, updates the phase, UA matcher, reply timer and try count, and hands its result to
// the output register. A start, or a timeout that resends, yields five transmit beats (flag,
// address, control, check, flag); a completed UA reply yields one "link up" beat and the last
// allowed timeout one "link failed" beat; all other beats yield nothing. Items that yield no
// result, or one arriving while the output is free, go at one per cycle; a beat that yields
// results waits in the input register until the previous result has fully left the output, so
// a frame occupies the output port for five accepted output beats. Configuration writes take
// effect at once and are meant for when the block is idle.
module link_setup_handshake (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic        last
);

	logic          valid_s1;
	logic [1:0]    op_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	logic          tx_free;
	lsh_pkg::req_t req;

	// an item leaves the input register once the output can take its result
	assign advance  = valid_s1 && (!req.valid || tx_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	lsh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (valid_s1),
		.op         (op_s1),
		.rx_byte    (byte_s1),
		.fire       (advance),
		.req        (req)
	);

	lsh_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.load      (advance),
		.free      (tx_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.tx_byte   (tx_byte),
		.last      (last)
	);

endmodule

// ----- design/lsh_ctrl.sv -----
// handshake control: config registers, phase, ua matcher, timer and try count
module lsh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               item_valid,
	input  logic [1:0]         op,
	input  logic [7:0]         rx_byte,
	input  logic               fire,
	output lsh_pkg::req_t      req
);

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic       REG_TIMEOUT = 1'b0;
	localparam logic       REG_TRIES   = 1'b1;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_UP   = 2'd2;
	localparam logic [1:0] PH_FAIL = 2'd3;

	localparam logic [2:0] M_START = 3'd0;
	localparam logic [2:0] M_FLAG  = 3'd1;
	localparam logic [2:0] M_ADDR  = 3'd2;
	localparam logic [2:0] M_CTRL  = 3'd3;
	localparam logic [2:0] M_CHECK = 3'd4;
	localparam logic [2:0] M_STOP  = 3'd5;

	localparam logic [7:0] FRAME_FLAG = 8'h7e;
	localparam logic [7:0] ADDR_BYTE  = 8'h03;
	localparam logic [7:0] CTRL_UA    = 8'h07;
	localparam logic [7:0] UA_CHECK   = ADDR_BYTE ^ CTRL_UA;

	logic [15:0] timeout_q;
	logic [3:0]  max_tries_q;
	logic [1:0]  phase_q, phase_d;
	logic [2:0]  match_q, match_d;
	logic [15:0] timer_q, timer_d;
	logic [3:0]  tries_q, tries_d;
	logic [1:0]  res;
	logic        ua_done;
	logic [2:0]  match_nx;
	logic [16:0] timer_inc;
	logic [3:0]  tries_inc;

	// ua frame matcher, one byte per step
	always_comb begin
		match_nx = M_START;
		ua_done  = 1'b0;
		case (match_q)
			M_STOP: begin
				match_nx = M_STOP;
			end
			M_FLAG: begin
				if (rx_byte == ADDR_BYTE) match_nx = M_ADDR;
				else if (rx_byte == FRAME_FLAG) match_nx = M_FLAG;
			end
			M_ADDR: begin
				if (rx_byte == CTRL_UA) match_nx = M_CTRL;
				else if (rx_byte == FRAME_FLAG) match_nx = M_FLAG;
			end
			M_CTRL: begin
				if (rx_byte == UA_CHECK) match_nx = M_CHECK;
				else if (rx_byte == FRAME_FLAG) match_nx = M_FLAG;
			end
			M_CHECK: begin
				if (rx_byte == FRAME_FLAG) begin
					match_nx = M_STOP;
					ua_done  = 1'b1;
				end
			end
			default: begin
				if (rx_byte == FRAME_FLAG) match_nx = M_FLAG;
			end
		endcase
	end

	assign timer_inc = {1'b0, timer_q} + 17'd1;
	assign tries_inc = tries_q + 4'd1;

	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		timer_d = timer_q;
		tries_d = tries_q;
		res     = lsh_pkg::RES_NONE;
		case (op)
			OP_START: begin
				phase_d = PH_WAIT;
				match_d = M_START;
				timer_d = '0;
				tries_d = '0;
				res     = lsh_pkg::RES_FRAME;
			end
			OP_BYTE: begin
				if (phase_q == PH_WAIT) begin
					match_d = match_nx;
					if (ua_done) begin
						phase_d = PH_UP;
						timer_d = '0;
						tries_d = '0;
						res     = lsh_pkg::RES_UP;
					end
				end
			end
			OP_TICK: begin
				if (phase_q == PH_WAIT) begin
					if (timer_inc < {1'b0, timeout_q}) begin
						timer_d = timer_inc[15:0];
					end else begin
						timer_d = '0;
						tries_d = tries_inc;
						if (tries_inc >= max_tries_q) begin
							phase_d = PH_FAIL;
							res     = lsh_pkg::RES_FAIL;
						end else begin
							res = lsh_pkg::RES_FRAME;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign req.valid = item_valid && (res != lsh_pkg::RES_NONE);
	assign req.res   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= 16'd8;
			max_tries_q <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT: timeout_q   <= cfg_data;
				REG_TRIES:   max_tries_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			match_q <= M_START;
			timer_q <= '0;
			tries_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			match_q <= match_d;
			timer_q <= timer_d;
			tries_q <= tries_d;
		end
	end

endmodule

// ----- design/lsh_tx.sv -----
// result register: plays out a frame beat by beat or a single status beat
module lsh_tx (
	input  logic          clk,
	input  logic          arst_n,
	input  lsh_pkg::req_t req,
	input  logic          load,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    kind,
	output logic [7:0]    tx_byte,
	output logic          last
);

	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_UP   = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;

	localparam logic [7:0] FRAME_FLAG = 8'h7e;
	localparam logic [7:0] ADDR_BYTE  = 8'h03;
	localparam logic [7:0] CTRL_SET   = 8'h03;
	localparam logic [2:0] LAST_BEAT  = 3'd4;

	logic       busy_q;
	logic [2:0] cnt_q;
	logic [1:0] res_q;
	logic       done;
	logic       take;

	always_comb begin
		tx_byte = '0;
		kind    = KIND_TX;
		last    = 1'b1;
		case (res_q)
			lsh_pkg::RES_FRAME: begin
				kind = KIND_TX;
				last = (cnt_q == LAST_BEAT);
				case (cnt_q)
					3'd0:    tx_byte = FRAME_FLAG;
					3'd1:    tx_byte = ADDR_BYTE;
					3'd2:    tx_byte = CTRL_SET;
					3'd3:    tx_byte = ADDR_BYTE ^ CTRL_SET;
					default: tx_byte = FRAME_FLAG;
				endcase
			end
			lsh_pkg::RES_UP:   kind = KIND_UP;
			lsh_pkg::RES_FAIL: kind = KIND_FAIL;
			default:           kind = KIND_FAIL;
		endcase
	end

	assign out_valid = busy_q;
	assign done      = busy_q && out_ready && last;
	assign free      = !busy_q || done;
	assign take      = load && req.valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			res_q  <= lsh_pkg::RES_NONE;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			res_q  <= req.res;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && res_q == lsh_pkg::RES_FRAME |-> cnt_q <= LAST_BEAT)
		else $error("frame beat count past end");

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy_q && cnt_q == 3'd0)
		else $error("loaded result not presented from first beat");

	a_frame_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_ready && !last |=> busy_q && res_q == $past(res_q))
		else $error("frame dropped before final beat");

	a_no_idle_nonframe: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> res_q != lsh_pkg::RES_NONE)
		else $error("empty result presented");

endmodule

// ----- tb/link_setup_handshake_test.sv -----
// self-checking testbench for the link set-up handshake block
`timescale 1ns / 100ps

module link_setup_handshake_test;

	typedef enum logic [1:0] {OP_START, OP_BYTE, OP_TICK, OP_SPARE} op_e;
	typedef enum logic [1:0] {KIND_TX, KIND_UP, KIND_FAIL} kind_e;
	typedef enum logic [1:0] {PH_IDLE, PH_WAITING, PH_UP, PH_FAILED} phase_e;
	typedef enum logic [2:0] {M_START, M_FLAG, M_ADDR, M_CTRL, M_CHECK, M_STOP} match_e;

	typedef struct {
		kind_e      kind;
		logic [7:0] tx_byte;
		logic       last;
	} link_beat_t;

	localparam logic       REG_TIMEOUT   = 1'b0;
	localparam logic       REG_MAX_TRIES = 1'b1;
	localparam logic [7:0] FLAG          = 8'h7E;
	localparam logic [7:0] ADDR          = 8'h03;
	localparam logic [7:0] CTRL_SET      = 8'h03;
	localparam logic [7:0] CTRL_UA       = 8'h07;
	localparam logic [7:0] UA_CHECK      = ADDR ^ CTRL_UA;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_SPARE;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        last;

	// predictor copy of the block state and registers
	logic [15:0] timeout_q = 16'd8;
	logic [3:0]  max_tries_q = 4'd3;
	phase_e      phase_q = PH_IDLE;
	match_e      match_q = M_START;
	logic [15:0] timer_q = '0;
	logic [3:0]  tries_q = '0;

	link_beat_t  pending_beats[$];
	int          mismatches = 0;
	int          live_items = 0;
	int          ready_hold_req = 0;
	bit          tx_gaps_on = 1'b1;
	bit          rx_stalls_on = 1'b1;

	link_setup_handshake u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.tx_byte   (tx_byte),
		.last      (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100) begin
			$display("%0t: %s", $time, what);
		end
	endtask

	task automatic push_beat(input kind_e k, input logic [7:0] b, input logic l);
		link_beat_t e;
		e.kind = k;
		e.tx_byte = b;
		e.last = l;
		pending_beats.push_back(e);
	endtask

	task automatic push_set_frame();
		push_beat(KIND_TX, FLAG, 1'b0);
		push_beat(KIND_TX, ADDR, 1'b0);
		push_beat(KIND_TX, CTRL_SET, 1'b0);
		push_beat(KIND_TX, ADDR ^ CTRL_SET, 1'b0);
		push_beat(KIND_TX, FLAG, 1'b1);
	endtask

	// ua matcher: until the stop state, a stray flag resynchronises, anything else drops to start
	task automatic ua_match(input logic [7:0] c, output bit done);
		match_e nxt;
		nxt = M_START;
		done = 1'b0;
		if (match_q != M_STOP) begin
			case (match_q)
				M_FLAG: begin
					if (c == ADDR) nxt = M_ADDR;
					else if (c == FLAG) nxt = M_FLAG;
				end
				M_ADDR: begin
					if (c == CTRL_UA) nxt = M_CTRL;
					else if (c == FLAG) nxt = M_FLAG;
				end
				M_CTRL: begin
					if (c == UA_CHECK) nxt = M_CHECK;
					else if (c == FLAG) nxt = M_FLAG;
				end
				M_CHECK: begin
					if (c == FLAG) begin
						nxt = M_STOP;
						done = 1'b1;
					end
				end
				default: begin
					if (c == FLAG) nxt = M_FLAG;
				end
			endcase
			match_q = nxt;
		end
	endtask

	task automatic predict_link(input op_e op, input logic [7:0] c, output bit live);
		logic [16:0] t;
		bit done;
		live = 1'b0;
		if (op == OP_START) begin
			live = 1'b1;
			phase_q = PH_WAITING;
			tries_q = '0;
			timer_q = '0;
			match_q = M_START;
			push_set_frame();
		end else if (phase_q == PH_WAITING && op == OP_BYTE) begin
			live = 1'b1;
			ua_match(c, done);
			if (done) begin
				phase_q = PH_UP;
				tries_q = '0;
				timer_q = '0;
				push_beat(KIND_UP, 8'h00, 1'b1);
			end
		end else if (phase_q == PH_WAITING && op == OP_TICK) begin
			live = 1'b1;
			t = {1'b0, timer_q} + 17'd1;
			if (t < {1'b0, timeout_q}) begin
				timer_q = t[15:0];
			end else begin
				timer_q = '0;
				tries_q = tries_q + 4'd1;
				if (tries_q >= max_tries_q) begin
					phase_q = PH_FAILED;
					push_beat(KIND_FAIL, 8'h00, 1'b1);
				end else begin
					push_set_frame();
				end
			end
		end
	endtask

	task automatic send_item(input op_e op, input logic [7:0] c);
		int gap;
		bit live;
		gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= c;
		do @(posedge clk); while (!in_ready);
		predict_link(op, c, live);
		if (live) live_items++;
	endtask

	// the sender stops offering and waits for every outstanding result
	task automatic wait_drained(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TIMEOUT) timeout_q = val;
		else max_tries_q = val[3:0];
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] ticks, input logic [3:0] tries);
		wait_drained(6);
		write_reg(REG_TIMEOUT, ticks);
		write_reg(REG_MAX_TRIES, {12'd0, tries});
	endtask

	task automatic send_ua_reply(input bit corrupt);
		logic [7:0] ua[5];
		int bad;
		ua = '{FLAG, ADDR, CTRL_UA, UA_CHECK, FLAG};
		bad = corrupt ? int'($urandom_range(0, 4)) : -1;
		if ($urandom_range(0, 3) == 0) send_item(OP_BYTE, FLAG);
		for (int i = 0; i < 5; i++) begin
			if ($urandom_range(0, 3) == 0) send_item(OP_TICK, 8'($urandom_range(0, 255)));
			send_item(OP_BYTE, (i == bad) ? 8'($urandom_range(0, 255)) : ua[i]);
		end
	endtask

	task automatic test_ignored_when_idle();
		send_item(OP_BYTE, FLAG);
		send_item(OP_TICK, 8'h00);
		send_item(OP_SPARE, 8'hFF);
	endtask

	task automatic test_link_up();
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, FLAG);
		send_item(OP_BYTE, ADDR);
		send_item(OP_BYTE, CTRL_UA);
		send_item(OP_BYTE, UA_CHECK);
		send_item(OP_BYTE, FLAG);
		send_item(OP_TICK, 8'hFF);
		// restart from up, then again while still waiting
		send_item(OP_START, 8'hA5);
		send_item(OP_START, 8'h5A);
	endtask

	task automatic test_retry_keeps_matcher();
		set_config(16'd2, 4'd3);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, FLAG);
		send_item(OP_BYTE, ADDR);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, CTRL_UA);
		send_item(OP_BYTE, UA_CHECK);
		send_item(OP_BYTE, FLAG);
	endtask

	task automatic test_give_up();
		set_config(16'd1, 4'd2);
		send_item(OP_START, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_item(OP_START, 8'h00);
		// zero registers: first tick times out and that timeout already fails
		set_config(16'd0, 4'd0);
		send_item(OP_START, 8'h00);
		send_item(OP_TICK, 8'h00);
	endtask

	task automatic test_backpressure();
		set_config(16'd8, 4'd3);
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		ready_hold_req = 120;
		send_item(OP_START, 8'h00);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, FLAG);
		send_item(OP_START, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_ua_reply(1'b0);
		wait_drained(6);
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	task automatic random_episode();
		int pick;
		int n;
		if ($urandom_range(0, 4) == 0) begin
			tx_gaps_on = 1'b0;
			rx_stalls_on = 1'b0;
		end else begin
			tx_gaps_on = $urandom_range(0, 3) != 0;
			rx_stalls_on = $urandom_range(0, 3) != 0;
		end
		send_item(OP_START, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			send_ua_reply(1'b0);
		end else if (pick < 7) begin
			send_ua_reply(1'b1);
		end else if (pick < 9) begin
			n = timeout_q * max_tries_q + 1;
			if (n > 30) n = 30;
			repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
		end else begin
			repeat (8) send_item(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		end
		// trailing beats, mostly ignored once the link is up or given up
		repeat ($urandom_range(0, 2))
			send_item(op_e'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
	endtask

	task automatic random_phase(input logic [15:0] ticks, input logic [3:0] tries);
		int phase_end;
		set_config(ticks, tries);
		phase_end = live_items + 52;
		while (live_items < phase_end) random_episode();
	endtask

	task automatic test_random();
		random_phase(16'd3, 4'd2);
		random_phase(16'd1, 4'd15);
		random_phase(16'hFFFF, 4'd15);
		random_phase(16'd1, 4'd1);
		random_phase(16'd6, 4'd4);
		random_phase(16'd2, 4'd3);
	endtask

	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			if (ready_hold_req > 0) begin
				stall = ready_hold_req;
				ready_hold_req = 0;
			end else begin
				stall = rx_stalls_on ? $urandom_range(0, 14) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && ready_hold_req == 0);
		end
	end

	always @(posedge clk) begin : result_check
		link_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat kind %0d byte %h", kind, tx_byte));
			end else begin
				want = pending_beats.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (tx_byte !== want.tx_byte)
					report_mismatch($sformatf("tx_byte %h, want %h", tx_byte, want.tx_byte));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b", last, want.last));
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_ignored_when_idle();
		test_link_up();
		test_retry_keeps_matcher();
		test_give_up();
		test_backpressure();
		test_random();
		wait_drained(10);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/lsh_pkg.sv
design/lsh_ctrl.sv
design/lsh_tx.sv
design/link_setup_handshake.sv
tb/link_setup_handshake_test.sv
